[sv/config_text_lexer_defines.svh]
// Assertion macros for the lexer checker.
`ifndef CONFIG_TEXT_LEXER_DEFINES_SVH
`define CONFIG_TEXT_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cfglex_pkg.sv]
package cfglex_pkg;

  localparam int MAX_HEX_DIGITS_DEF = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [3:0] KIND_TEXT    = 4'd0;
  localparam logic [3:0] KIND_NUMBER  = 4'd1;
  localparam logic [3:0] KIND_ADDR    = 4'd2;
  localparam logic [3:0] KIND_BOOL    = 4'd3;
  localparam logic [3:0] KIND_KEYWORD = 4'd4;
  localparam logic [3:0] KIND_STRING  = 4'd5;
  localparam logic [3:0] KIND_OPEN    = 4'd6;
  localparam logic [3:0] KIND_CLOSE   = 4'd7;
  localparam logic [3:0] KIND_EOF     = 4'd8;
  localparam logic [3:0] KIND_INVALID = 4'd9;
  localparam logic [3:0] KIND_UEOF    = 4'd10;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [7:0]  text_byte;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(logic [3:0] k, logic [63:0] v, logic [7:0] tb);
    res_t r;
    r.kind      = k;
    r.value     = v;
    r.text_byte = tb;
    r.last      = 1'b0;
    return r;
  endfunction

  // Expected character of "true" or "false" at a match position.
  function automatic logic [7:0] word_char(logic is_false, logic [2:0] idx);
    logic [7:0] w;
    w = 8'h00;
    if (is_false) begin
      case (idx)
        3'd0: w = "f";
        3'd1: w = "a";
        3'd2: w = "l";
        3'd3: w = "s";
        3'd4: w = "e";
        default: w = 8'h00;
      endcase
    end else begin
      case (idx[1:0])
        2'd0: w = "t";
        2'd1: w = "r";
        2'd2: w = "u";
        2'd3: w = "e";
        default: w = 8'h00;
      endcase
    end
    return w;
  endfunction

endpackage

[sv/cfglex_front.sv]
module cfglex_front #(
  parameter int MAX_HEX_DIGITS = cfglex_pkg::MAX_HEX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfglex_pkg::in_t    in_data,
  input  logic               room,
  output cfglex_pkg::push_t  push
);
  import cfglex_pkg::*;

  localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 1);
  localparam logic [2:0] WM_NONE = 3'd7;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ZERO = 7'b0000010,
    S_HEX  = 7'b0000100,
    S_DEC  = 7'b0001000,
    S_WORD = 7'b0010000,
    S_STR  = 7'b0100000,
    S_CMT  = 7'b1000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [2:0]       wm_r, wm_nxt;
  logic             accept;
  res_t             ra, ri;
  logic             have_a, go_idle, emit_i;

  assign in_ready = room;
  assign accept   = in_valid && room;

  always_comb begin
    logic [7:0]  c, l, want;
    logic        fin, hex_ok, dig_ok, word_ok, quote, is_f;
    logic [7:0]  hv;
    logic [35:0] prod;
    logic [2:0]  wlen;
    c       = in_data.ch;
    fin     = in_data.at_end;
    l       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    dig_ok  = c >= "0" && c <= "9";
    hex_ok  = dig_ok || (l >= "a" && l <= "f");
    hv      = dig_ok ? c - "0" : l - "a" + 8'd10;
    word_ok = (l >= "a" && l <= "z") || c == "-";
    quote   = c == "\"" || c == "'";
    is_f    = acc_r[0];
    wlen    = is_f ? 3'd5 : 3'd4;
    want    = word_char(is_f, wm_r);
    prod    = {1'b0, acc_r[31:0], 3'b000} + {3'b000, acc_r[31:0], 1'b0} + {28'd0, c - "0"};
    st_nxt  = st_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    wm_nxt  = wm_r;
    ra      = mk_res(KIND_TEXT, 64'd0, 8'd0);
    ri      = mk_res(KIND_TEXT, 64'd0, 8'd0);
    have_a  = 1'b0;
    go_idle = 1'b0;
    emit_i  = 1'b0;
    case (st_r)
      S_ZERO: begin
        if (!fin && l == "x") begin
          st_nxt  = S_HEX;
          acc_nxt = 64'd0;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end else begin
          ra      = mk_res(KIND_NUMBER, 64'd0, 8'd0);
          have_a  = 1'b1;
          go_idle = 1'b1;
        end
      end
      S_HEX: begin
        if (!fin && hex_ok) begin
          if (cnt_r >= CNT_W'(MAX_HEX_DIGITS)) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = {acc_r[59:0], hv[3:0]};
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          ra      = (cnt_r == '0 || ovf_r) ? mk_res(KIND_INVALID, 64'd0, 8'd0)
                                           : mk_res(KIND_ADDR, acc_r, 8'd0);
          have_a  = 1'b1;
          go_idle = 1'b1;
        end
      end
      S_DEC: begin
        if (!fin && dig_ok) begin
          if (!ovf_r) begin
            acc_nxt = {28'd0, prod};
            if (prod > 36'h07FFFFFFF) begin
              ovf_nxt = 1'b1;
            end
          end
        end else begin
          ra      = ovf_r ? mk_res(KIND_INVALID, 64'd0, 8'd0)
                          : mk_res(KIND_NUMBER, acc_r, 8'd0);
          have_a  = 1'b1;
          go_idle = 1'b1;
        end
      end
      S_WORD: begin
        if (!fin && word_ok) begin
          if (wm_r != WM_NONE) begin
            wm_nxt = (wm_r < wlen && l == want) ? wm_r + 3'd1 : WM_NONE;
          end
          ra     = mk_res(KIND_TEXT, 64'd0, l);
          have_a = 1'b1;
        end else begin
          ra      = (wm_r == wlen) ? mk_res(KIND_BOOL, {63'd0, !is_f}, 8'd0)
                                   : mk_res(KIND_KEYWORD, 64'd0, 8'd0);
          have_a  = 1'b1;
          go_idle = 1'b1;
        end
      end
      S_STR: begin
        if (fin || quote) begin
          ra      = mk_res(fin ? KIND_UEOF : KIND_STRING, 64'd0, 8'd0);
          have_a  = 1'b1;
          st_nxt  = S_IDLE;
          acc_nxt = 64'd0;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
          wm_nxt  = 3'd0;
        end else begin
          ra     = mk_res(KIND_TEXT, 64'd0, c);
          have_a = 1'b1;
        end
      end
      S_CMT: begin
        if (fin || c == 8'h0A) begin
          ra      = mk_res(KIND_EOF, 64'd0, 8'd0);
          have_a  = fin;
          st_nxt  = S_IDLE;
          acc_nxt = 64'd0;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
          wm_nxt  = 3'd0;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      st_nxt  = S_IDLE;
      acc_nxt = 64'd0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
      wm_nxt  = 3'd0;
      emit_i  = 1'b1;
      if (fin) begin
        ri = mk_res(KIND_EOF, 64'd0, 8'd0);
      end else if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
        emit_i = 1'b0;
      end else if (c == "0") begin
        st_nxt = S_ZERO;
        emit_i = 1'b0;
      end else if (c >= "1" && c <= "9") begin
        st_nxt  = S_DEC;
        acc_nxt = {56'd0, c - "0"};
        emit_i  = 1'b0;
      end else if (l >= "a" && l <= "z") begin
        st_nxt  = S_WORD;
        acc_nxt = {63'd0, l == "f"};
        wm_nxt  = (l == "t" || l == "f") ? 3'd1 : WM_NONE;
        ri      = mk_res(KIND_TEXT, 64'd0, l);
      end else if (c == "[") begin
        ri = mk_res(KIND_OPEN, 64'd0, 8'd0);
      end else if (c == "]") begin
        ri = mk_res(KIND_CLOSE, 64'd0, 8'd0);
      end else if (quote) begin
        st_nxt = S_STR;
        emit_i = 1'b0;
      end else if (c == "#") begin
        st_nxt = S_CMT;
        emit_i = 1'b0;
      end else begin
        ri = mk_res(KIND_INVALID, 64'd0, 8'd0);
      end
    end
  end

  always_comb begin
    push.cnt = 2'd0;
    push.r0  = ra;
    push.r1  = ri;
    if (have_a && emit_i) begin
      push.cnt     = 2'd2;
      push.r1.last = 1'b1;
    end else if (have_a) begin
      push.cnt     = 2'd1;
      push.r0.last = 1'b1;
    end else if (emit_i) begin
      push.cnt     = 2'd1;
      push.r0      = ri;
      push.r0.last = 1'b1;
    end
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      acc_r <= 64'd0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      wm_r  <= 3'd0;
    end else if (accept) begin
      st_r  <= st_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      wm_r  <= wm_nxt;
    end
  end

endmodule

[sv/cfglex_queue.sv]
module cfglex_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cfglex_pkg::push_t  push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output cfglex_pkg::res_t   out_data
);
  import cfglex_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  res_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = mem[rp_r];
  assign pop       = out_valid && out_ready;
  assign room      = cnt_r <= CNT_W'(QUEUE_DEPTH - 2);
  assign wp_nxt    = wp_r + PTR_W'(push.cnt);
  assign rp_nxt    = rp_r + PTR_W'(pop);
  assign cnt_nxt   = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_r + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/config_text_lexer.sv]
// Channel  Direction  Payload                              Handshake
// in_      input      in_t    {ch, at_end}                 in_valid / in_ready
// out_     output     res_t   {kind, value, text_byte, last} out_valid / out_ready
//
// One input byte is accepted per cycle while the result queue has two free slots.
// Each accepted byte yields zero, one or two results; the output drains one per cycle
// while out_ready is high, so a byte with two results needs two output transfers.
// Results appear on out_ in the cycle after their byte is accepted, at the earliest.
// Reset is synchronous on rst_n low; the queue empties and the lexer returns to idle.
// A stalled output drops in_ready once three of the four queue entries are taken.
module config_text_lexer #(
  parameter int MAX_HEX_DIGITS = cfglex_pkg::MAX_HEX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfglex_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cfglex_pkg::res_t  out_data
);
  import cfglex_pkg::*;

  push_t push;
  logic  room;

  cfglex_front #(
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  cfglex_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/cfglex_checker.sv]
`include "config_text_lexer_defines.svh"

module cfglex_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input cfglex_pkg::res_t  out_data
);
  import cfglex_pkg::*;

  `CTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data), "output request changed while stalled")
  `CTL_ASSERT_NOW(a_kind_range, out_valid, out_data.kind <= KIND_UEOF,
    "result kind out of range")
  `CTL_ASSERT_NOW(a_value_zero, out_valid && out_data.kind != KIND_NUMBER &&
    out_data.kind != KIND_ADDR && out_data.kind != KIND_BOOL, out_data.value == 64'd0,
    "value set on a kind without value")
  `CTL_ASSERT_NOW(a_bool_bit, out_valid && out_data.kind == KIND_BOOL,
    out_data.value[63:1] == 63'd0, "boolean value not 0 or 1")
  `CTL_ASSERT_NOW(a_text_zero, out_valid && out_data.kind != KIND_TEXT,
    out_data.text_byte == 8'd0, "text byte set on a closing result")

endmodule

bind config_text_lexer cfglex_checker u_cfglex_checker (.*);

[verif/tb_config_text_lexer.sv]
`timescale 1ns / 1ps

module tb_config_text_lexer;
  import cfglex_pkg::*;

  typedef enum logic [2:0] {
    LX_IDLE, LX_ZERO, LX_HEX, LX_DEC, LX_WORD, LX_STR, LX_CMT
  } lex_state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
    logic       typed;
    logic [3:0] kind;
  } row_t;

  localparam logic [2:0]  WPOS_NONE   = 3'd7;
  localparam logic [31:0] TRUE_WORD   = "true";
  localparam logic [39:0] FALSE_WORD  = "false";
  localparam int          HEX_LIMIT   = MAX_HEX_DIGITS_DEF;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          LONG_HOLD   = 150;
  localparam int          IDLE_LIMIT  = 1000;
  localparam int          NUM_ROWS    = 26;

  logic  clk;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  res_t  out_data;

  config_text_lexer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  lex_state_e  ls;
  logic [63:0] acc;
  logic [4:0]  ndig;
  logic        ovf;
  logic [2:0]  wpos;

  res_t  step_results[$];
  res_t  expected_tokens[$];
  in_t   token_bytes[$];
  row_t  script[NUM_ROWS];
  res_t  want_r;
  int    mismatch_count = 0;
  int    items_sent = 0;
  int    idle_cycles = 0;
  int    sender_calm = 0;
  int    receiver_calm = 0;

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic int hex_value(logic [7:0] c);
    logic [7:0] l;
    l = fold_case(c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (l >= "a" && l <= "f") return int'(l - "a") + 10;
    return -1;
  endfunction

  function automatic void emit(logic [3:0] k, logic [63:0] v, logic [7:0] tb);
    res_t r;
    r.kind = k;
    r.value = v;
    r.text_byte = tb;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void drop_token();
    ls = LX_IDLE;
    acc = '0;
    ndig = '0;
    ovf = 1'b0;
    wpos = '0;
  endfunction

  function automatic void start_token(logic [7:0] c, logic eot);
    logic [7:0] l;
    drop_token();
    l = fold_case(c);
    if (eot) begin
      emit(KIND_EOF, 64'd0, 8'd0);
    end else if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
      ls = LX_IDLE;
    end else if (c == "0") begin
      ls = LX_ZERO;
    end else if (c >= "1" && c <= "9") begin
      acc = {56'd0, c - "0"};
      ls = LX_DEC;
    end else if (is_letter(c)) begin
      acc = (l == "f") ? 64'd1 : 64'd0;
      wpos = (l == "t" || l == "f") ? 3'd1 : WPOS_NONE;
      ls = LX_WORD;
      emit(KIND_TEXT, 64'd0, l);
    end else if (c == "[") begin
      emit(KIND_OPEN, 64'd0, 8'd0);
    end else if (c == "]") begin
      emit(KIND_CLOSE, 64'd0, 8'd0);
    end else if (c == "\"" || c == "'") begin
      ls = LX_STR;
    end else if (c == "#") begin
      ls = LX_CMT;
    end else begin
      emit(KIND_INVALID, 64'd0, 8'd0);
    end
  endfunction

  function automatic void lex_predict(logic [7:0] c, logic eot);
    int h;
    int widx;
    int wlen;
    logic [7:0] l;
    logic [7:0] want;
    res_t r;
    step_results.delete();
    l = fold_case(c);
    wlen = (acc != 0) ? 5 : 4;
    case (ls)
      LX_ZERO: begin
        if (!eot && l == "x") begin
          ls = LX_HEX;
          acc = '0;
          ndig = '0;
          ovf = 1'b0;
        end else begin
          emit(KIND_NUMBER, 64'd0, 8'd0);
          start_token(c, eot);
        end
      end
      LX_HEX: begin
        h = eot ? -1 : hex_value(c);
        if (h >= 0) begin
          if (ndig >= HEX_LIMIT) begin
            ovf = 1'b1;
          end else begin
            acc = {acc[59:0], h[3:0]};
            ndig++;
          end
        end else begin
          if (ndig == 0 || ovf) emit(KIND_INVALID, 64'd0, 8'd0);
          else emit(KIND_ADDR, acc, 8'd0);
          start_token(c, eot);
        end
      end
      LX_DEC: begin
        if (!eot && c >= "0" && c <= "9") begin
          if (!ovf) begin
            acc = acc * 64'd10 + (c - "0");
            if (acc > 64'h7FFF_FFFF) ovf = 1'b1;
          end
        end else begin
          if (ovf) emit(KIND_INVALID, 64'd0, 8'd0);
          else emit(KIND_NUMBER, acc, 8'd0);
          start_token(c, eot);
        end
      end
      LX_WORD: begin
        if (!eot && (is_letter(c) || c == "-")) begin
          if (wpos != WPOS_NONE) begin
            widx = int'(wpos);
            want = 8'd0;
            if (widx < wlen)
              want = (acc != 0) ? FALSE_WORD[39-8*widx -: 8] : TRUE_WORD[31-8*(widx%4) -: 8];
            wpos = (widx < wlen && l == want) ? wpos + 3'd1 : WPOS_NONE;
          end
          emit(KIND_TEXT, 64'd0, l);
        end else begin
          if (wpos == wlen) emit(KIND_BOOL, (acc != 0) ? 64'd0 : 64'd1, 8'd0);
          else emit(KIND_KEYWORD, 64'd0, 8'd0);
          start_token(c, eot);
        end
      end
      LX_STR: begin
        if (eot) begin
          emit(KIND_UEOF, 64'd0, 8'd0);
          drop_token();
        end else if (c == "\"" || c == "'") begin
          emit(KIND_STRING, 64'd0, 8'd0);
          drop_token();
        end else begin
          emit(KIND_TEXT, 64'd0, c);
        end
      end
      LX_CMT: begin
        if (eot) begin
          emit(KIND_EOF, 64'd0, 8'd0);
          drop_token();
        end else if (c == 8'h0A) begin
          drop_token();
        end
      end
      default: start_token(c, eot);
    endcase
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endfunction

  function automatic void queue_byte(logic [7:0] c, logic eot);
    in_t t;
    t.ch = c;
    t.at_end = eot;
    token_bytes.push_back(t);
  endfunction

  function automatic void queue_letter(logic [7:0] c);
    if (c != "-" && $urandom_range(0, 1)) c = c - 8'd32;
    queue_byte(c, 1'b0);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return 8'h09;
      2: return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  function automatic void queue_decimal(logic [63:0] v);
    logic [7:0] d[$];
    do begin
      d.push_front(8'("0" + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (d[i]) queue_byte(d[i], 1'b0);
  endfunction

  function automatic void build_token();
    int sel;
    int n;
    int h;
    logic pick_false;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      queue_byte(pick_blank(), 1'b0);
    end else if (sel < 14) begin
      queue_byte($urandom_range(0, 1) ? "[" : "]", 1'b0);
    end else if (sel < 30) begin
      if ($urandom_range(0, 9) == 0) queue_byte("0", 1'b0);
      case ($urandom_range(0, 4))
        0: queue_decimal(64'd2147483647 + $urandom_range(0, 1));
        1: queue_decimal($urandom_range(0, 1) ? 64'd4294967295 : 64'd2147483646);
        2: queue_decimal({$urandom, $urandom} % 64'd1000000000000);
        default: queue_decimal(64'($urandom_range(0, 9999)));
      endcase
    end else if (sel < 44) begin
      queue_byte("0", 1'b0);
      queue_byte($urandom_range(0, 1) ? "x" : "X", 1'b0);
      case ($urandom_range(0, 5))
        0: n = 0;
        1: n = $urandom_range(15, 18);
        default: n = $urandom_range(1, 8);
      endcase
      for (int i = 0; i < n; i++) begin
        h = $urandom_range(0, 15);
        if (h < 10) c = 8'("0" + h);
        else c = 8'(($urandom_range(0, 1) ? "a" : "A") + h - 10);
        queue_byte(c, 1'b0);
      end
    end else if (sel < 62) begin
      sel = $urandom_range(0, 3);
      if (sel == 3) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          queue_letter(8'((i > 0 && $urandom_range(0, 5) == 0) ?
                          "-" : "a" + $urandom_range(0, 25)));
      end else begin
        pick_false = $urandom_range(0, 1);
        n = pick_false ? 5 : 4;
        if (sel == 1) n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++)
          queue_letter(pick_false ? FALSE_WORD[39-8*i -: 8] : TRUE_WORD[31-8*i -: 8]);
        if (sel == 2)
          queue_letter(8'($urandom_range(0, 3) == 0 ? "-" : "a" + $urandom_range(0, 25)));
      end
    end else if (sel < 74) begin
      queue_byte($urandom_range(0, 1) ? "\"" : "'", 1'b0);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == "\"" || c == "'");
        queue_byte(c, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b1);
      else queue_byte($urandom_range(0, 1) ? "\"" : "'", 1'b0);
    end else if (sel < 80) begin
      queue_byte("#", 1'b0);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == 8'h0A);
        queue_byte(c, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b1);
      else queue_byte(8'h0A, 1'b0);
    end else if (sel < 92) begin
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    if ($urandom_range(0, 9) < 4) queue_byte(pick_blank(), 1'b0);
  endfunction

  task automatic send_request(in_t item, logic typed, logic [3:0] typed_kind);
    int gap;
    res_t r;
    gap = draw_wait(sender_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lex_predict(item.ch, item.at_end);
    if (typed) begin
      r.kind = typed_kind;
      r.value = 64'd0;
      r.text_byte = 8'd0;
      r.last = 1'b1;
      expected_tokens.push_back(r);
    end else begin
      foreach (step_results[i]) expected_tokens.push_back(step_results[i]);
    end
    items_sent++;
  endtask

  initial begin : sender
    in_t item;
    script[0]  = '{"[",   1'b0, 1'b1, KIND_OPEN};
    script[1]  = '{"]",   1'b0, 1'b1, KIND_CLOSE};
    script[2]  = '{8'hFF, 1'b0, 1'b1, KIND_INVALID};
    script[3]  = '{"@",   1'b0, 1'b1, KIND_INVALID};
    script[4]  = '{8'h00, 1'b1, 1'b1, KIND_EOF};
    script[5]  = '{"0",   1'b0, 1'b0, KIND_TEXT};
    script[6]  = '{"X",   1'b0, 1'b0, KIND_TEXT};
    script[7]  = '{"]",   1'b0, 1'b0, KIND_TEXT};
    script[8]  = '{"0",   1'b0, 1'b0, KIND_TEXT};
    script[9]  = '{"7",   1'b0, 1'b0, KIND_TEXT};
    script[10] = '{8'hA5, 1'b1, 1'b0, KIND_TEXT};
    script[11] = '{"T",   1'b0, 1'b0, KIND_TEXT};
    script[12] = '{"r",   1'b0, 1'b0, KIND_TEXT};
    script[13] = '{"U",   1'b0, 1'b0, KIND_TEXT};
    script[14] = '{"e",   1'b0, 1'b0, KIND_TEXT};
    script[15] = '{" ",   1'b0, 1'b0, KIND_TEXT};
    script[16] = '{"\"",  1'b0, 1'b0, KIND_TEXT};
    script[17] = '{"A",   1'b0, 1'b0, KIND_TEXT};
    script[18] = '{8'h5A, 1'b1, 1'b1, KIND_UEOF};
    script[19] = '{"#",   1'b0, 1'b0, KIND_TEXT};
    script[20] = '{"z",   1'b0, 1'b0, KIND_TEXT};
    script[21] = '{8'hFF, 1'b1, 1'b1, KIND_EOF};
    script[22] = '{"k",   1'b0, 1'b0, KIND_TEXT};
    script[23] = '{"-",   1'b0, 1'b0, KIND_TEXT};
    script[24] = '{"'",   1'b0, 1'b0, KIND_TEXT};
    script[25] = '{"'",   1'b0, 1'b0, KIND_TEXT};
    drop_token();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      item.ch = script[i].ch;
      item.at_end = script[i].at_end;
      send_request(item, script[i].typed, script[i].kind);
    end

    while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
      build_token();
      while (token_bytes.size() > 0) send_request(token_bytes.pop_front(), 1'b0, KIND_TEXT);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : receiver
    int stall;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = draw_wait(receiver_calm);
      // hold off once so the result queue fills and in_ready drops
      if (taken == 100 && !held) begin
        held = 1'b1;
        stall = LONG_HOLD;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: result kind %0d value %0h with nothing expected",
                 $time, out_data.kind, out_data.value);
        mismatch_count++;
      end else begin
        want_r = expected_tokens.pop_front();
        if (out_data.kind !== want_r.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want_r.kind, out_data.kind);
          mismatch_count++;
        end
        if (out_data.value !== want_r.value) begin
          $display("%0t: value expected %0h actual %0h", $time, want_r.value, out_data.value);
          mismatch_count++;
        end
        if (out_data.text_byte !== want_r.text_byte) begin
          $display("%0t: text_byte expected %0h actual %0h",
                   $time, want_r.text_byte, out_data.text_byte);
          mismatch_count++;
        end
        if (out_data.last !== want_r.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want_r.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
